### rtl/hbd_pkg.sv
// Shared constants, command codes and the table entry type of the Huffman table bit decoder.
// No dependencies; hbd_entry_cmp and the top level refer to this package by scoped names.
package hbd_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W   = 8;
    localparam int ELEN_W  = 6;
    localparam int CODE_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int BCNT_W  = 4;
    localparam int CMD_W   = 2;

    localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int PLEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int PC_W    = MAX_CODE_LEN;
    localparam int CMP_W   = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int CLEN_W  = (PLEN_W > ELEN_W) ? PLEN_W : ELEN_W;

    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

    localparam int IN_TDATA_W  = 64;
    localparam int OFS_SYMBOL  = 0;
    localparam int OFS_LENGTH  = OFS_SYMBOL + SYM_W;
    localparam int OFS_CODE    = OFS_LENGTH + ELEN_W;
    localparam int OFS_BYTE    = OFS_CODE + CODE_W;
    localparam int OFS_BCNT    = OFS_BYTE + BYTE_W;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [ELEN_W-1:0] length;
        logic [CODE_W-1:0] code;
    } entry_t;

endpackage

### rtl/hbd_table_ram.sv
// Single-port-write, single-port-read code table memory with a registered read.
// No dependencies.
module hbd_table_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 46
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hbd_entry_cmp.sv
// Shared compare unit: tests one table entry against the partial code and its length.
// Depends on hbd_pkg.
module hbd_entry_cmp (
    input  hbd_pkg::entry_t                entry,
    input  logic [hbd_pkg::PC_W-1:0]       partial,
    input  logic [hbd_pkg::PLEN_W-1:0]     plen,
    output logic                           hit
);

    logic [hbd_pkg::CMP_W-1:0]  mask;
    logic [hbd_pkg::CMP_W-1:0]  code_ext;
    logic [hbd_pkg::CMP_W-1:0]  part_ext;
    logic [hbd_pkg::CLEN_W-1:0] len_ext;
    logic [hbd_pkg::CLEN_W-1:0] plen_ext;

    always_comb
    begin
        len_ext  = hbd_pkg::CLEN_W'(entry.length);
        plen_ext = hbd_pkg::CLEN_W'(plen);
        code_ext = hbd_pkg::CMP_W'(entry.code);
        part_ext = hbd_pkg::CMP_W'(partial);
        for (int i = 0; i < hbd_pkg::CMP_W; i++)
        begin
            mask[i] = (hbd_pkg::CLEN_W'(i) < len_ext);
        end
        hit = (len_ext != '0)
            && (len_ext <= hbd_pkg::CLEN_W'(hbd_pkg::MAX_CODE_LEN))
            && (len_ext == plen_ext)
            && ((code_ext & mask) == part_ext);
    end

endmodule

### rtl/huffman_table_bit_decoder.sv
// Top level of the Huffman table bit decoder: command sequencer, partial code and output stage.
// Depends on hbd_pkg, hbd_table_ram and hbd_entry_cmp.
//
//  Channel   Direction  Fields (lowest bit first)
//  s_axis    in         tuser: cmd; tdata: symbol, code_length, code_bits, data_byte, bit_count
//  m_axis    out        tuser: code_error; tdata: out_symbol; tlast: last
//
// Start and load commands are handled in the idle state, which stays ready for the next command.
// A decode command, for each consumed bit, shifts the bit into the partial code, searches
// the loaded entries in order through the registered table read, and hands on a symbol or
// an error when one is found.
// After reset the table is empty and the partial code is clear; the table memory is not cleared.
// A stalled output holds the sequencer when a second result of the same byte is ready, and at
// the end of a byte while its final result waits for the output register.
module huffman_table_bit_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // symbol, code_length, code_bits, data_byte, bit_count, zeros
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_symbol
    output logic [0:0]  m_axis_tuser,  // code_error
    output logic        m_axis_tlast   // last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIT   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]                      state_reg,    state_next;
    logic [hbd_pkg::CNT_W-1:0]       cnt_reg,      cnt_next;
    logic [hbd_pkg::PC_W-1:0]        partial_reg,  partial_next;
    logic [hbd_pkg::PLEN_W-1:0]      plen_reg,     plen_next;
    logic [hbd_pkg::BCNT_W-1:0]      left_reg,     left_next;
    logic [hbd_pkg::CNT_W-1:0]       idx_reg,      idx_next;
    logic                            cmp_vld_reg,  cmp_vld_next;
    logic                            hold_vld_reg, hold_vld_next;
    logic                            out_vld_reg,  out_vld_next;
    logic [hbd_pkg::BYTE_W-1:0]      byte_reg,     byte_next;
    logic [hbd_pkg::SYM_W-1:0]       res_sym_reg,  res_sym_next;
    logic                            res_err_reg,  res_err_next;
    logic [hbd_pkg::SYM_W-1:0]       hold_sym_reg, hold_sym_next;
    logic                            hold_err_reg, hold_err_next;
    logic [hbd_pkg::SYM_W-1:0]       out_sym_reg,  out_sym_next;
    logic                            out_err_reg,  out_err_next;
    logic                            out_last_reg, out_last_next;

    logic                            accept;
    logic [hbd_pkg::CMD_W-1:0]       in_cmd;
    logic [hbd_pkg::BCNT_W-1:0]      in_bcnt;
    hbd_pkg::entry_t                 in_entry;
    hbd_pkg::entry_t                 rd_entry;
    logic                            ram_we;
    logic                            hit;
    logic                            issue;
    logic                            out_free;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_cmd   = s_axis_tuser;
    assign in_bcnt  = s_axis_tdata[hbd_pkg::OFS_BCNT +: hbd_pkg::BCNT_W];
    assign in_entry.symbol = s_axis_tdata[hbd_pkg::OFS_SYMBOL +: hbd_pkg::SYM_W];
    assign in_entry.length = s_axis_tdata[hbd_pkg::OFS_LENGTH +: hbd_pkg::ELEN_W];
    assign in_entry.code   = s_axis_tdata[hbd_pkg::OFS_CODE +: hbd_pkg::CODE_W];

    assign ram_we   = accept && (in_cmd == hbd_pkg::CMD_LOAD)
                      && (cnt_reg < hbd_pkg::CNT_W'(hbd_pkg::MAX_ENTRIES));
    assign issue    = (idx_reg < cnt_reg);
    assign out_free = !out_vld_reg || m_axis_tready;

    hbd_table_ram #(
        .ADDR_W (hbd_pkg::ADDR_W),
        .DATA_W ($bits(hbd_pkg::entry_t))
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[hbd_pkg::ADDR_W-1:0]),
        .wdata (in_entry),
        .raddr (idx_reg[hbd_pkg::ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    hbd_entry_cmp u_cmp (
        .entry   (rd_entry),
        .partial (partial_reg),
        .plen    (plen_reg),
        .hit     (hit)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        partial_next  = partial_reg;
        plen_next     = plen_reg;
        left_next     = left_reg;
        idx_next      = idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        hold_vld_next = hold_vld_reg;
        out_vld_next  = out_vld_reg;
        byte_next     = byte_reg;
        res_sym_next  = res_sym_reg;
        res_err_next  = res_err_reg;
        hold_sym_next = hold_sym_reg;
        hold_err_next = hold_err_reg;
        out_sym_next  = out_sym_reg;
        out_err_next  = out_err_reg;
        out_last_next = out_last_reg;

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_cmd == hbd_pkg::CMD_START)
                    begin
                        cnt_next     = '0;
                        partial_next = '0;
                        plen_next    = '0;
                    end
                    else if (in_cmd == hbd_pkg::CMD_LOAD)
                    begin
                        if (ram_we)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else if (in_cmd == hbd_pkg::CMD_DECODE)
                    begin
                        byte_next  = s_axis_tdata[hbd_pkg::OFS_BYTE +: hbd_pkg::BYTE_W];
                        left_next  = (in_bcnt > hbd_pkg::BCNT_W'(hbd_pkg::BYTE_W))
                                     ? hbd_pkg::BCNT_W'(hbd_pkg::BYTE_W) : in_bcnt;
                        state_next = S_BIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_BIT:
            begin
                if (left_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    partial_next = hbd_pkg::PC_W'({partial_reg, byte_reg[hbd_pkg::BYTE_W-1]});
                    plen_next    = plen_reg + 1'b1;
                    byte_next    = {byte_reg[hbd_pkg::BYTE_W-2:0], 1'b0};
                    left_next    = left_reg - 1'b1;
                    idx_next     = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (cmp_vld_reg && hit)
                begin
                    res_sym_next = rd_entry.symbol;
                    res_err_next = 1'b0;
                    partial_next = '0;
                    plen_next    = '0;
                    state_next   = S_EMIT;
                end
                else if (issue)
                begin
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                else if (plen_reg == hbd_pkg::PLEN_W'(hbd_pkg::MAX_CODE_LEN))
                begin
                    res_sym_next = '0;
                    res_err_next = 1'b1;
                    partial_next = '0;
                    plen_next    = '0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    state_next = S_BIT;
                end
            end
            S_EMIT:
            begin
                if (!hold_vld_reg)
                begin
                    hold_vld_next = 1'b1;
                    hold_sym_next = res_sym_reg;
                    hold_err_next = res_err_reg;
                    state_next    = S_BIT;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_sym_next  = hold_sym_reg;
                    out_err_next  = hold_err_reg;
                    out_last_next = 1'b0;
                    hold_sym_next = res_sym_reg;
                    hold_err_next = res_err_reg;
                    state_next    = S_BIT;
                end
            end
            S_FLUSH:
            begin
                if (!hold_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_sym_next  = hold_sym_reg;
                    out_err_next  = hold_err_reg;
                    out_last_next = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            partial_reg  <= '0;
            plen_reg     <= '0;
            left_reg     <= '0;
            idx_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            partial_reg  <= partial_next;
            plen_reg     <= plen_next;
            left_reg     <= left_next;
            idx_reg      <= idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        res_sym_reg  <= res_sym_next;
        res_err_reg  <= res_err_next;
        hold_sym_reg <= hold_sym_next;
        hold_err_reg <= hold_err_next;
        out_sym_reg  <= out_sym_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tuser  = out_err_reg;
    assign m_axis_tlast  = out_last_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hbd_pkg::CNT_W'(hbd_pkg::MAX_ENTRIES))
        else $error("Table entry count exceeds the table depth.");

    a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= hbd_pkg::PLEN_W'(hbd_pkg::MAX_CODE_LEN))
        else $error("Partial code length exceeds the maximum code length.");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (idx_reg <= cnt_reg))
        else $error("Search index ran past the loaded entries.");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_vld_reg)
        else $error("A held result was left behind when the byte finished.");

    a_emit_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && hold_vld_reg && out_free) |=> (out_vld_reg && !out_last_reg))
        else $error("A displaced result did not reach the output as a non-final transfer.");

endmodule
